[rtl/core/assert_macros.svh]
// assertion macros used by rse_control
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

[rtl/core/rse_pkg.sv]
// shared types and constants of the row softmax engine
// no dependencies
`timescale 1ns / 1ps
package rse_pkg;
   localparam int unsigned SampleWidth = 16;
   localparam int unsigned ExpWidth    = 17;
   localparam int unsigned ProbWidth   = 16;
   localparam logic [16:0] Log2eQ16    = 17'd94548;
   localparam logic [15:0] ProbMax     = 16'hFFFF;

   typedef struct packed {
      logic clear_row;
      logic exp_load;
      logic exp_step;
      logic exp_write;
      logic div_start;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   function automatic logic [16:0] pow2_frac(input logic [3:0] f);
      logic [16:0] r;
      begin
         unique case (f)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd62757;
            4'd2:  r = 17'd60097;
            4'd3:  r = 17'd57549;
            4'd4:  r = 17'd55109;
            4'd5:  r = 17'd52773;
            4'd6:  r = 17'd50535;
            4'd7:  r = 17'd48393;
            4'd8:  r = 17'd46341;
            4'd9:  r = 17'd44376;
            4'd10: r = 17'd42495;
            4'd11: r = 17'd40693;
            4'd12: r = 17'd38968;
            4'd13: r = 17'd37316;
            4'd14: r = 17'd35734;
            default: r = 17'd34219;
         endcase
         return r;
      end
   endfunction
endpackage

[rtl/core/rse_ram.sv]
// generic single port write, single port registered read ram
// no dependencies
`timescale 1ns / 1ps
module rse_ram #(
   parameter int unsigned Width = 16,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/rse_datapath.sv]
// datapath: row and exponential stores, max, exp pipeline, sum, serial divider
// depends on rse_pkg, rse_ram
`timescale 1ns / 1ps
module rse_datapath import rse_pkg::*; #(
   parameter int unsigned MaxCols = 64,
   localparam int unsigned AW = $clog2(MaxCols)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [SampleWidth-1:0] sample,
   input  logic [AW-1:0]         rd_addr,
   input  logic [AW-1:0]         exp_wr_addr,
   input  logic [AW-1:0]         div_addr,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [ProbWidth-1:0]  quotient
);
   logic signed [15:0] max_ff, max_in;
   logic [15:0] row_rd;
   logic [16:0] exp_rd;
   logic [15:0] diff_ff;
   logic [32:0] t_ff;
   logic [16:0] e_val;
   logic [22:0] sum_ff, sum_in;
   logic [22:0] divisor;
   logic [22:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff;
   logic [23:0] trial;

   rse_ram #(.Width(SampleWidth), .Depth(MaxCols)) u_row (
      .clock, .wr_en, .wr_addr, .wr_data(sample), .rd_addr, .rd_data(row_rd));

   rse_ram #(.Width(ExpWidth), .Depth(MaxCols)) u_exp (
      .clock, .wr_en(cmd.exp_write), .wr_addr(exp_wr_addr), .wr_data(e_val),
      .rd_addr(div_addr), .rd_data(exp_rd));

   always_comb begin
      max_in = max_ff;
      if (cmd.clear_row) begin
         max_in = 16'sh8000;
      end else if (wr_en && ($signed(sample) > max_ff)) begin
         max_in = $signed(sample);
      end
   end

   // exponential: diff, multiply, table and shift, zero when the shift exceeds 16
   always_comb begin
      if (t_ff[32:24] > 9'd16) begin
         e_val = '0;
      end else begin
         e_val = pow2_frac(t_ff[23:20]) >> t_ff[28:24];
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (cmd.clear_row) begin
         sum_in = '0;
      end else if (cmd.exp_write) begin
         sum_in = sum_ff + 23'(e_val);
      end
   end

   assign divisor = (sum_ff == '0) ? 23'd1 : sum_ff;
   assign trial   = {rem_ff, quo_ff[32]};

   // restoring divider, one quotient bit a cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (cmd.div_start) begin
         rem_in  = '0;
         quo_in  = {exp_rd, 16'd0};
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = 23'(trial - {1'b0, divisor});
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = trial[22:0];
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= 16'sh8000;
         sum_ff  <= '0;
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         max_ff  <= max_in;
         sum_ff  <= sum_in;
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= busy_ff && (cnt_ff == 6'd1);
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.exp_load) begin
         diff_ff <= 16'(max_ff - $signed(row_rd));
      end
      if (cmd.exp_step) begin
         t_ff <= {17'd0, diff_ff} * {16'd0, Log2eQ16};
      end
   end

   assign status.div_done = done_ff;
   assign quotient = (quo_ff[32:16] != '0) ? ProbMax : quo_ff[15:0];
endmodule

[rtl/core/rse_control.sv]
// controller: collects a row, sequences exponentials and divisions
// depends on rse_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rse_control import rse_pkg::*; #(
   parameter int unsigned MaxCols = 64,
   localparam int unsigned AW = $clog2(MaxCols),
   localparam int unsigned CW = $clog2(MaxCols + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_row_end,
   output logic        wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [AW-1:0] rd_addr,
   output logic [AW-1:0] exp_wr_addr,
   output logic [AW-1:0] div_addr,
   output cmd_type     cmd,
   input  status_type  status,
   output logic        out_load,
   output logic        out_last,
   output logic        out_trunc,
   input  logic        out_free
);
   typedef enum logic [2:0] {
      S_COLLECT, S_EXP_RD, S_EXP_LD, S_EXP_MUL, S_EXP_WR,
      S_DIV_RD, S_DIV_RUN, S_DIV_OUT
   } state_type;

   state_type   state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] idx_ff;
   logic        trunc_ff;
   logic        div_started_ff;
   logic        accept;
   logic        last_idx;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_COLLECT);
   assign wr_en     = accept && (count_ff < CW'(MaxCols));
   assign wr_addr   = count_ff[AW-1:0];
   assign rd_addr   = idx_ff[AW-1:0];
   assign exp_wr_addr = idx_ff[AW-1:0];
   assign div_addr  = idx_ff[AW-1:0];
   assign last_idx  = (idx_ff + CW'(1) == count_ff);

   always_comb begin
      cmd = '0;
      cmd.clear_row = (state_ff == S_DIV_OUT) && out_free && last_idx;
      cmd.exp_load  = (state_ff == S_EXP_LD);
      cmd.exp_step  = (state_ff == S_EXP_MUL);
      cmd.exp_write = (state_ff == S_EXP_WR);
      cmd.div_start = (state_ff == S_DIV_RUN) && !div_started_ff;
   end

   assign out_load  = (state_ff == S_DIV_OUT) && out_free;
   assign out_last  = last_idx;
   assign out_trunc = trunc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         count_ff <= '0;
         idx_ff   <= '0;
         trunc_ff <= 1'b0;
         div_started_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_COLLECT: begin
               if (accept) begin
                  if (count_ff < CW'(MaxCols)) begin
                     count_ff <= count_ff + CW'(1);
                  end else begin
                     trunc_ff <= 1'b1;
                  end
                  if (req_row_end) begin
                     idx_ff   <= '0;
                     state_ff <= S_EXP_RD;
                  end
               end
            end
            S_EXP_RD:  state_ff <= S_EXP_LD;
            S_EXP_LD:  state_ff <= S_EXP_MUL;
            S_EXP_MUL: state_ff <= S_EXP_WR;
            S_EXP_WR: begin
               if (last_idx) begin
                  idx_ff   <= '0;
                  state_ff <= S_DIV_RD;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_EXP_RD;
               end
            end
            S_DIV_RD: begin
               div_started_ff <= 1'b0;
               state_ff <= S_DIV_RUN;
            end
            S_DIV_RUN: begin
               div_started_ff <= 1'b1;
               if (status.div_done) begin
                  state_ff <= S_DIV_OUT;
               end
            end
            S_DIV_OUT: begin
               if (out_free) begin
                  if (last_idx) begin
                     count_ff <= '0;
                     trunc_ff <= 1'b0;
                     state_ff <= S_COLLECT;
                  end else begin
                     idx_ff   <= idx_ff + CW'(1);
                     state_ff <= S_DIV_RD;
                  end
               end
            end
            default: state_ff <= S_COLLECT;
         endcase
      end
   end

   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MaxCols))
   `ASSERT_IMPL(a_idx_bound, clock, reset, state_ff != S_COLLECT, idx_ff < count_ff)
   `ASSERT_NEXT(a_load_back, clock, reset, out_load && last_idx, state_ff == S_COLLECT)
endmodule

[rtl/core/row_softmax_engine_unit.sv]
// top level of the row softmax engine
// depends on rse_pkg, rse_control, rse_datapath
`timescale 1ns / 1ps
// Row softmax with max subtraction. Samples (signed Q8.8) are taken one per
// cycle until row_end; the block then computes 2^-((max-x)*log2 e) per element
// in the steps S_EXP_RD, S_EXP_LD, S_EXP_MUL and S_EXP_WR, sums them, and
// divides each value by the sum with a radix-2 restoring divider, emitting
// results in arrival order. A stalled receiver adds its wait to each result.
// The divider sets the rate. Samples beyond MAX_COLS are dropped and flagged.
module row_softmax_engine_unit import rse_pkg::*; #(
   parameter int unsigned MAX_COLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_sample,
   input  logic        req_row_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_prob,
   output logic        rsp_row_last,
   output logic        rsp_truncated
);
   localparam int unsigned AW = $clog2(MAX_COLS);

   cmd_type       cmd;
   status_type    status;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr, exp_wr_addr, div_addr;
   logic          out_load, out_last, out_trunc, out_free;
   logic [15:0]   quotient;
   logic          valid_ff;
   logic [15:0]   prob_ff;
   logic          last_ff, trunc_ff;

   assign out_free = !valid_ff || rsp_ready;

   rse_control #(.MaxCols(MAX_COLS)) u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_row_end, .wr_en, .wr_addr,
      .rd_addr, .exp_wr_addr, .div_addr, .cmd, .status, .out_load, .out_last,
      .out_trunc, .out_free);

   rse_datapath #(.MaxCols(MAX_COLS)) u_dp (
      .clock, .reset, .wr_en, .wr_addr, .sample(req_sample), .rd_addr,
      .exp_wr_addr, .div_addr, .cmd, .status, .quotient);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (out_load) begin
         prob_ff  <= quotient;
         last_ff  <= out_last;
         trunc_ff <= out_trunc;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_prob      = prob_ff;
   assign rsp_row_last  = last_ff;
   assign rsp_truncated = trunc_ff;
endmodule

[test/row_softmax_engine_unit_tb.sv]
// testbench for row_softmax_engine_unit: rows of samples in, softmax results out
// depends on rse_pkg and the row_softmax_engine_unit rtl; checks against a built-in predictor
`timescale 1ns / 1ps
module row_softmax_engine_unit_tb;
   import rse_pkg::*;

   localparam int unsigned MaxCols = 64;
   localparam int unsigned IdleLimit = 200000;

   typedef struct packed {
      logic [15:0] sample;
      logic        row_end;
   } sample_req_t;

   typedef struct packed {
      logic [15:0] prob;
      logic        row_last;
      logic        truncated;
   } prob_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_sample = '0;
   logic        req_row_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_prob;
   logic        rsp_row_last;
   logic        rsp_truncated;

   sample_req_t pending_reqs[$];
   prob_rsp_t   expected_probs[$];

   // predictor state
   logic signed [15:0] row_samples[MaxCols];
   int unsigned        row_count = 0;
   logic signed [15:0] row_peak = 16'sh8000;
   logic               row_dropped = 1'b0;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  recv_hold = 1'b0;
   bit  failed = 1'b0;
   int unsigned idle_cycles = 0;
   int unsigned sent_count = 0;
   int unsigned queued_count = 0;

   row_softmax_engine_unit #(.MAX_COLS(MaxCols)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample(req_sample), .req_row_end(req_row_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_prob(rsp_prob), .rsp_row_last(rsp_row_last),
      .rsp_truncated(rsp_truncated)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [16:0] neg_pow2(input logic [15:0] diff);
      logic [40:0] t;
      logic [16:0] base;
      begin
         t = diff * 41'd94548;
         if (t[40:24] > 17'd16) return 17'd0;
         case (t[23:20])
            4'd0:  base = 17'd65536;
            4'd1:  base = 17'd62757;
            4'd2:  base = 17'd60097;
            4'd3:  base = 17'd57549;
            4'd4:  base = 17'd55109;
            4'd5:  base = 17'd52773;
            4'd6:  base = 17'd50535;
            4'd7:  base = 17'd48393;
            4'd8:  base = 17'd46341;
            4'd9:  base = 17'd44376;
            4'd10: base = 17'd42495;
            4'd11: base = 17'd40693;
            4'd12: base = 17'd38968;
            4'd13: base = 17'd37316;
            4'd14: base = 17'd35734;
            default: base = 17'd34219;
         endcase
         return base >> t[28:24];
      end
   endfunction

   task automatic predict_softmax(input sample_req_t r);
      logic [16:0] exps[MaxCols];
      logic [22:0] total;
      logic [32:0] q;
      prob_rsp_t   p;
      begin
         if (row_count < MaxCols) begin
            row_samples[row_count] = r.sample;
            row_count++;
            if ($signed(r.sample) > row_peak) row_peak = r.sample;
         end else begin
            row_dropped = 1'b1;
         end
         if (r.row_end) begin
            total = '0;
            for (int i = 0; i < row_count; i++) begin
               exps[i] = neg_pow2(16'(row_peak - row_samples[i]));
               total += exps[i];
            end
            if (total == 0) total = 23'd1;
            for (int i = 0; i < row_count; i++) begin
               q = {exps[i], 16'd0} / total;
               p.prob = (q > 33'd65535) ? ProbMax : q[15:0];
               p.row_last = (i + 1 == row_count);
               p.truncated = row_dropped;
               expected_probs.push_back(p);
            end
            row_count = 0;
            row_peak = 16'sh8000;
            row_dropped = 1'b0;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predict_softmax('{req_sample, req_row_end});
            sent_count <= sent_count + 1;
         end
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            sample_req_t r;
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_sample <= r.sample;
            req_row_end <= r.row_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_probs.size() == 0) begin
               $error("unexpected result prob=%0d", rsp_prob);
               failed = 1'b1;
            end else begin
               prob_rsp_t e;
               e = expected_probs.pop_front();
               if (rsp_prob !== e.prob) begin
                  $error("prob expected %0d actual %0d", e.prob, rsp_prob);
                  failed = 1'b1;
               end
               if (rsp_row_last !== e.row_last) begin
                  $error("row_last expected %0d actual %0d", e.row_last, rsp_row_last);
                  failed = 1'b1;
               end
               if (rsp_truncated !== e.truncated) begin
                  $error("truncated expected %0d actual %0d", e.truncated, rsp_truncated);
                  failed = 1'b1;
               end
            end
         end
         rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic queue_row(input int len, input int mode);
      logic [15:0] s;
      int unsigned base;
      begin
         base = $urandom;
         for (int i = 0; i < len; i++) begin
            case (mode)
               0: s = $urandom;
               1: s = 16'(base + $urandom_range(0, 1023) - 512);
               default: s = 16'(base + $urandom_range(0, 63));
            endcase
            pending_reqs.push_back('{s, i == len - 1});
            queued_count++;
         end
      end
   endtask

   task automatic wait_drained;
      begin
         wait (pending_reqs.size() == 0 && sent_count == queued_count
               && expected_probs.size() == 0);
      end
   endtask

   task automatic random_rows(input int count);
      begin
         for (int n = 0; n < count; ) begin
            int len;
            len = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            if (len > count - n) len = count - n;
            queue_row(len, $urandom_range(2));
            n += len;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, single element, equal row, deep negatives, overflow
      pending_reqs.push_back('{16'h7FFF, 1'b1});
      pending_reqs.push_back('{16'h8000, 1'b1});
      pending_reqs.push_back('{16'h7FFF, 1'b0});
      pending_reqs.push_back('{16'h8000, 1'b1});
      pending_reqs.push_back('{16'h0000, 1'b0});
      pending_reqs.push_back('{16'h0000, 1'b0});
      pending_reqs.push_back('{16'h0000, 1'b1});
      pending_reqs.push_back('{16'h0100, 1'b0});
      pending_reqs.push_back('{16'h0000, 1'b0});
      pending_reqs.push_back('{16'hF000, 1'b0});
      pending_reqs.push_back('{16'hFFFF, 1'b1});
      pending_reqs.push_back('{16'h0B00, 1'b0});
      pending_reqs.push_back('{16'h0000, 1'b1});
      queued_count = 13;
      queue_row(MaxCols + 3, 0);
      wait_drained();

      // no idling, then sender idles, receiver stalls, and both
      random_rows(80);
      wait_drained();
      send_idle_pct = 70;
      random_rows(70);
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 70;
      random_rows(70);
      wait_drained();
      send_idle_pct = 10;
      recv_stall_pct = 10;
      random_rows(70);
      wait_drained();

      // long receiver hold-off so the block backs up
      send_idle_pct = 0;
      recv_stall_pct = 0;
      recv_hold = 1'b1;
      random_rows(50);
      repeat (3000) @(posedge clock);
      recv_hold = 1'b0;
      wait_drained();

      send_idle_pct = 30;
      recv_stall_pct = 30;
      random_rows(60);
      wait_drained();

      repeat (200) @(posedge clock);
      if (failed || expected_probs.size() != 0) begin
         $display("TB_ERROR");
      end else begin
         $display("TB_OK");
      end
      $finish;
   end
endmodule
